FILE: hw/rtl/serial_frame_validator_unit_defines.svh
// ----------------------------------------------------------------------------
// Serial frame validator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_VALIDATOR_UNIT_DEFINES_SVH
`define SERIAL_FRAME_VALIDATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define SFV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/sfv_pkg.sv
// ----------------------------------------------------------------------------
// sfv_pkg
// Types, codes and constants shared by the serial frame validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfv_pkg;

	localparam int MAX_FRAME_BYTES = 128;
	localparam int CNT_W           = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 8;
	localparam int POS_W           = 7;
	localparam int WIN_DEPTH       = 9;
	localparam int BOOT_LEN        = 10;
	localparam int ACK_LEN         = 3;

	localparam logic [7:0] BOOT_TEXT [BOOT_LEN] = '{
		8'h42, 8'h6F, 8'h6F, 8'h74, 8'h6C, 8'h6F, 8'h61, 8'h64, 8'h65, 8'h72
	};
	localparam logic [7:0] ACK_TEXT [ACK_LEN] = '{8'h41, 8'h43, 8'h4B};

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BOOT_TEXT    = 3'd1,
		ST_ACK_TEXT     = 3'd2,
		ST_HEADER_ERR   = 3'd3,
		ST_LENGTH_ERR   = 3'd4,
		ST_CHECKSUM_ERR = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START0_VALUE = 3'd0,
		CFG_START1_VALUE = 3'd1,
		CFG_START0_POS   = 3'd2,
		CFG_START1_POS   = 3'd3,
		CFG_LENGTH_POS   = 3'd4,
		CFG_DATA_OFFSET  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]       start0_value;
		logic [7:0]       start1_value;
		logic [POS_W-1:0] start0_pos;
		logic [POS_W-1:0] start1_pos;
		logic [POS_W-1:0] length_pos;
		logic [POS_W-1:0] data_offset;
	} cfg_regs_t;

	typedef struct packed {
		logic boot;
		logic ack;
	} text_flags_t;

endpackage

FILE: hw/rtl/sfv_if.sv
// ----------------------------------------------------------------------------
// sfv_in_if / sfv_out_if
// Valid/ready channels for received bytes and frame verdicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sfv_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [6:0] frame_length;

	modport source (output valid, output status, output frame_length, input ready);
	modport sink   (input valid, input status, input frame_length, output ready);
endinterface

FILE: hw/rtl/sfv_text_scan.sv
// ----------------------------------------------------------------------------
// sfv_text_scan
// Byte window and text detectors, active up to the first zero byte of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfv_text_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 clear,
	input  logic [7:0]           data_byte,
	output sfv_pkg::text_flags_t found
);
	import sfv_pkg::*;

	logic [7:0]  win_q [WIN_DEPTH];
	logic        zero_q;
	text_flags_t flags_q;
	logic        boot_hit;
	logic        ack_hit;
	logic        scan_on;

	always_comb begin
		boot_hit = (data_byte == BOOT_TEXT[BOOT_LEN-1]);
		for (int k = 0; k < BOOT_LEN - 1; k++) begin
			if (win_q[WIN_DEPTH-(BOOT_LEN-1)+k] != BOOT_TEXT[k]) boot_hit = 1'b0;
		end
		ack_hit = (data_byte == ACK_TEXT[ACK_LEN-1]);
		for (int k = 0; k < ACK_LEN - 1; k++) begin
			if (win_q[WIN_DEPTH-(ACK_LEN-1)+k] != ACK_TEXT[k]) ack_hit = 1'b0;
		end
	end

	assign scan_on    = !zero_q && (data_byte != 8'd0);
	assign found.boot = flags_q.boot || (scan_on && boot_hit);
	assign found.ack  = flags_q.ack || (scan_on && ack_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_DEPTH; k++) win_q[k] <= 8'd0;
			zero_q  <= 1'b0;
			flags_q <= '0;
		end else if (step) begin
			if (clear) begin
				for (int k = 0; k < WIN_DEPTH; k++) win_q[k] <= 8'd0;
				zero_q  <= 1'b0;
				flags_q <= '0;
			end else begin
				for (int k = 0; k < WIN_DEPTH - 1; k++) win_q[k] <= win_q[k+1];
				win_q[WIN_DEPTH-1] <= data_byte;
				zero_q  <= zero_q || (data_byte == 8'd0);
				flags_q <= found;
			end
		end
	end

endmodule

FILE: hw/rtl/serial_frame_validator_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_validator_unit
// Checks received frames byte by byte and gives one verdict per frame.
// ----------------------------------------------------------------------------
// Usage:
//   frame_in carries one received byte per request, in arrival order, with
//   last_byte set on the final byte of a frame. verdict_out carries one
//   request per frame: status (0 ok, 1 boot text, 2 ack text, 3 header error,
//   4 length error, 5 checksum error) and frame_length, saturated at 127.
//   Bytes pass an input register, then update the frame state; on the last
//   byte the verdict is loaded into the output register. Throughput is one
//   byte per cycle unless a last byte waits in the input register for the
//   output register; the running sum, header capture and text window all
//   update in the single stage after the input register.
//   When verdict_out stalls with a verdict held, the next frame's bytes keep
//   flowing until a second last byte reaches the input register; that byte
//   then waits there and frame_in drops ready.
//   Reset clears all frame state, the registers to their defaults and both
//   channels to empty. Configure through cfg_we/cfg_index/cfg_wdata while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "serial_frame_validator_unit_defines.svh"

module serial_frame_validator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sfv_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfv_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	sfv_in_if.sink                           frame_in,
	sfv_out_if.source                        verdict_out
);
	import sfv_pkg::*;

	cfg_regs_t        cfg_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      sum_q;
	logic [7:0]       newer_q;
	logic [1:0]       hb_q;
	logic [7:0]       lb_q;

	logic             out_valid_q;
	status_t          status_q;
	logic [6:0]       flen_q;

	logic             out_free;
	logic             fire_s1;
	text_flags_t      text;
	logic [CNT_W-1:0] len_nxt;
	logic [1:0]       hb_nxt;
	logic [7:0]       lb_nxt;
	logic [7:0]       lb_eff;
	logic             h0;
	logic             h1;
	logic [15:0]      calc;
	logic [15:0]      got;
	status_t          status_nxt;
	logic [6:0]       flen_nxt;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start0_value <= 8'd0;
			cfg_q.start1_value <= 8'd0;
			cfg_q.start0_pos   <= 7'd0;
			cfg_q.start1_pos   <= 7'd1;
			cfg_q.length_pos   <= 7'd2;
			cfg_q.data_offset  <= 7'd4;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_START0_VALUE: cfg_q.start0_value <= cfg_wdata;
				CFG_START1_VALUE: cfg_q.start1_value <= cfg_wdata;
				CFG_START0_POS:   cfg_q.start0_pos   <= cfg_wdata[POS_W-1:0];
				CFG_START1_POS:   cfg_q.start1_pos   <= cfg_wdata[POS_W-1:0];
				CFG_LENGTH_POS:   cfg_q.length_pos   <= cfg_wdata[POS_W-1:0];
				CFG_DATA_OFFSET:  cfg_q.data_offset  <= cfg_wdata[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: a last byte in s1 waits for a free output register
	assign out_free       = !out_valid_q || verdict_out.ready;
	assign fire_s1        = valid_s1 && (!last_s1 || out_free);
	assign frame_in.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.ready) begin
			valid_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			byte_s1 <= frame_in.data_byte;
			last_s1 <= frame_in.last_byte;
		end
	end

	sfv_text_scan u_text_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (fire_s1),
		.clear     (last_s1),
		.data_byte (byte_s1),
		.found     (text)
	);

	// frame state after this byte
	always_comb begin
		len_nxt = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;
		hb_nxt  = hb_q;
		if (cnt_q == {1'b0, cfg_q.start0_pos} && byte_s1 == cfg_q.start0_value) hb_nxt[0] = 1'b1;
		if (cnt_q == {1'b0, cfg_q.start1_pos} && byte_s1 == cfg_q.start1_value) hb_nxt[1] = 1'b1;
		lb_nxt = (cnt_q == {1'b0, cfg_q.length_pos}) ? byte_s1 : lb_q;
	end

	// verdict; the trailing word is {this byte, previous byte}
	always_comb begin
		h0     = ({1'b0, cfg_q.start0_pos} < len_nxt) ? hb_nxt[0] : (cfg_q.start0_value == 8'd0);
		h1     = ({1'b0, cfg_q.start1_pos} < len_nxt) ? hb_nxt[1] : (cfg_q.start1_value == 8'd0);
		lb_eff = ({1'b0, cfg_q.length_pos} < len_nxt) ? lb_nxt : 8'd0;
		calc   = ~(sum_q - {8'd0, newer_q});
		got    = {byte_s1, newer_q};
		if ({1'b0, len_nxt} >= (CNT_W + 1)'(MAX_FRAME_BYTES)) begin
			status_nxt = ST_LENGTH_ERR;
		end else if (text.boot) begin
			status_nxt = ST_BOOT_TEXT;
		end else if (text.ack) begin
			status_nxt = ST_ACK_TEXT;
		end else if (!h0 || !h1) begin
			status_nxt = ST_HEADER_ERR;
		end else if (({1'b0, lb_eff} + 9'd2 != {1'b0, len_nxt}) ||
				(len_nxt <= {1'b0, cfg_q.data_offset})) begin
			status_nxt = ST_LENGTH_ERR;
		end else if (got != calc) begin
			status_nxt = ST_CHECKSUM_ERR;
		end else begin
			status_nxt = ST_OK;
		end
		flen_nxt = (len_nxt > 8'd127) ? 7'd127 : len_nxt[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= 16'd0;
			newer_q <= 8'd0;
			hb_q    <= 2'b00;
			lb_q    <= 8'd0;
		end else if (fire_s1) begin
			if (last_s1) begin
				cnt_q   <= '0;
				sum_q   <= 16'd0;
				newer_q <= 8'd0;
				hb_q    <= 2'b00;
				lb_q    <= 8'd0;
			end else begin
				cnt_q   <= len_nxt;
				sum_q   <= sum_q + {8'd0, byte_s1};
				newer_q <= byte_s1;
				hb_q    <= hb_nxt;
				lb_q    <= lb_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && last_s1) begin
			status_q <= status_nxt;
			flen_q   <= flen_nxt;
		end
	end

	assign verdict_out.valid        = out_valid_q;
	assign verdict_out.status       = status_q;
	assign verdict_out.frame_length = flen_q;

	`SFV_ASSERT_NEXT(a_verdict_loads, fire_s1 && last_s1, out_valid_q, "verdict not loaded after last byte")
	`SFV_ASSERT_NEXT(a_frame_cleared, fire_s1 && last_s1, cnt_q == '0, "frame state not cleared after verdict")
	`SFV_ASSERT_NOW(a_status_range, out_valid_q, status_q <= ST_CHECKSUM_ERR, "status code out of range")
	`SFV_ASSERT_NOW(a_hold_on_stall, valid_s1 && last_s1 && out_valid_q && !verdict_out.ready, !frame_in.ready, "byte taken while verdict blocked")

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb - serial frame validator testbench
// Sends received frames byte by byte through frame_in and checks each verdict
// against a predictor that tracks the byte sum, header and length capture and
// the text window. Covers well-formed, corrupted, text and overlong frames
// under several register settings, with random input gaps and verdict back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import sfv_pkg::*;

typedef struct {
	status_t    status;
	logic [6:0] flen;
} verdict_t;

class frame_check_scoreboard;
	logic [7:0]       s0_val, s1_val;
	logic [POS_W-1:0] s0_pos, s1_pos, len_pos, payload_off;

	logic [7:0]  count;
	logic [15:0] sum;
	logic [7:0]  prev2, prev1;
	logic [1:0]  hdr_hits;
	logic [7:0]  len_field;
	logic [7:0]  window [WIN_DEPTH];
	bit          zero_hit, boot_hit, ack_hit;

	verdict_t pending_verdicts[$];
	int       mismatches;
	int       verdicts_seen;
	int       status_hits [8];

	function new();
		s0_val = 8'h00;
		s1_val = 8'h00;
		s0_pos = 7'd0;
		s1_pos = 7'd1;
		len_pos = 7'd2;
		payload_off = 7'd4;
		mismatches = 0;
		verdicts_seen = 0;
		foreach (status_hits[i]) status_hits[i] = 0;
		clear_frame();
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] index, logic [7:0] value);
		case (index)
			CFG_START0_VALUE: s0_val = value;
			CFG_START1_VALUE: s1_val = value;
			CFG_START0_POS:   s0_pos = value[POS_W-1:0];
			CFG_START1_POS:   s1_pos = value[POS_W-1:0];
			CFG_LENGTH_POS:   len_pos = value[POS_W-1:0];
			CFG_DATA_OFFSET:  payload_off = value[POS_W-1:0];
			default: ;
		endcase
	endfunction

	function void clear_frame();
		count = '0;
		sum = '0;
		prev2 = '0;
		prev1 = '0;
		hdr_hits = '0;
		len_field = '0;
		foreach (window[i]) window[i] = '0;
		zero_hit = 0;
		boot_hit = 0;
		ack_hit = 0;
	endfunction

	// true when the word ends with the current byte and the window holds the rest
	function bit text_ends(string word, logic [7:0] cur);
		int n;
		n = word.len();
		if (word[n-1] != cur) return 0;
		for (int k = 0; k < n - 1; k++)
			if (window[WIN_DEPTH - (n - 1) + k] != word[k]) return 0;
		return 1;
	endfunction

	function void add_byte(logic [7:0] b, bit last);
		verdict_t v;
		int       flen;
		int       lb;
		bit       h0, h1;
		logic [15:0] body;
		logic [15:0] got;

		if (count == s0_pos && b == s0_val) hdr_hits[0] = 1'b1;
		if (count == s1_pos && b == s1_val) hdr_hits[1] = 1'b1;
		if (count == len_pos) len_field = b;

		if (!zero_hit) begin
			if (b == 8'h00) begin
				zero_hit = 1;
			end else begin
				if (text_ends("Bootloader", b)) boot_hit = 1;
				if (text_ends("ACK", b)) ack_hit = 1;
			end
		end
		for (int i = 0; i < WIN_DEPTH - 1; i++) window[i] = window[i+1];
		window[WIN_DEPTH-1] = b;

		sum = sum + b;
		prev2 = prev1;
		prev1 = b;
		if (count != 8'hFF) count = count + 8'd1;

		if (!last) return;

		flen = count;
		if (flen >= MAX_FRAME_BYTES) begin
			v.status = ST_LENGTH_ERR;
		end else if (boot_hit) begin
			v.status = ST_BOOT_TEXT;
		end else if (ack_hit) begin
			v.status = ST_ACK_TEXT;
		end else begin
			// a start byte past the end of the frame reads as zero
			h0 = (s0_pos < flen) ? hdr_hits[0] : (s0_val == 8'h00);
			h1 = (s1_pos < flen) ? hdr_hits[1] : (s1_val == 8'h00);
			if (!h0 || !h1) begin
				v.status = ST_HEADER_ERR;
			end else begin
				lb = (len_pos < flen) ? len_field : 0;
				if (lb + 2 != flen || flen <= payload_off) begin
					v.status = ST_LENGTH_ERR;
				end else begin
					body = sum - prev2 - prev1;
					got = {prev1, prev2};
					v.status = (got != ~body) ? ST_CHECKSUM_ERR : ST_OK;
				end
			end
		end
		v.flen = (flen > 127) ? 7'd127 : flen[6:0];
		pending_verdicts.push_back(v);
		clear_frame();
	endfunction

	function void match_verdict(logic [2:0] status, logic [6:0] flen);
		verdict_t v;
		verdicts_seen++;
		if (pending_verdicts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: verdict %0d/%0d arrived with none awaited",
					$realtime, status, flen);
			return;
		end
		v = pending_verdicts.pop_front();
		status_hits[v.status]++;
		if (status !== v.status || flen !== v.flen) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: verdict mismatch: expected status %0d length %0d, got %0d %0d",
					$realtime, v.status, v.flen, status, flen);
		end
	endfunction
endclass

module tb;
	localparam int LIMIT_CYCLES   = 250000;
	localparam int HOLD_OFF_LEN   = 60;
	localparam int SETTLE_CYCLES  = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	sfv_in_if  frame_in ();
	sfv_out_if verdict_out ();

	serial_frame_validator_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.frame_in    (frame_in),
		.verdict_out (verdict_out)
	);

	frame_check_scoreboard sb = new();

	logic [7:0] frame_buf[$];
	int         bytes_sent;
	int         frames_sent;
	int         cycles;
	bit         quiet_tail;
	bit         hold_off_req;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && verdict_out.valid && verdict_out.ready)
			sb.match_verdict(verdict_out.status, verdict_out.frame_length);
	end

	// verdict receiver: random stalls, plus one long hold-off on request
	initial begin : verdict_sink
		int burst;
		verdict_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				verdict_out.ready <= 1'b0;
				repeat (HOLD_OFF_LEN) @(negedge clk);
			end
			if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 4);
				verdict_out.ready <= 1'b0;
				repeat (burst) @(negedge clk);
			end
			verdict_out.ready <= 1'b1;
		end
	end

	task automatic write_cfg(logic [CFG_IDX_W-1:0] index, logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(index, value);
	endtask

	task automatic apply_cfg(logic [7:0] v0, logic [7:0] v1, logic [7:0] p0,
			logic [7:0] p1, logic [7:0] pl, logic [7:0] off);
		write_cfg(CFG_START0_VALUE, v0);
		write_cfg(CFG_START1_VALUE, v1);
		write_cfg(CFG_START0_POS, p0);
		write_cfg(CFG_START1_POS, p1);
		write_cfg(CFG_LENGTH_POS, pl);
		write_cfg(CFG_DATA_OFFSET, off);
	endtask

	task automatic send_byte(logic [7:0] b, bit last);
		int gap;
		@(negedge clk);
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 4);
			frame_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		frame_in.valid <= 1'b1;
		frame_in.data_byte <= b;
		frame_in.last_byte <= last;
		do @(posedge clk); while (!frame_in.ready);
		sb.add_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_frame();
		foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frames_sent++;
	endtask

	// wait out every awaited verdict, then let the block settle
	task automatic drain();
		@(negedge clk);
		frame_in.valid <= 1'b0;
		while (sb.pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// frame with header, length field and checksum set for the current settings
	task automatic build_valid_frame(int flen);
		logic [15:0] acc;
		acc = '0;
		frame_buf.delete();
		for (int i = 0; i < flen; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
		if (sb.s0_pos < flen) frame_buf[sb.s0_pos] = sb.s0_val;
		if (sb.s1_pos < flen) frame_buf[sb.s1_pos] = sb.s1_val;
		if (sb.len_pos < flen) frame_buf[sb.len_pos] = 8'(flen - 2);
		for (int i = 0; i < flen - 2; i++) acc = acc + frame_buf[i];
		acc = ~acc;
		frame_buf[flen-2] = acc[7:0];
		frame_buf[flen-1] = acc[15:8];
	endtask

	task automatic build_noise_frame(int flen);
		frame_buf.delete();
		for (int i = 0; i < flen; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic append_text(string word);
		for (int i = 0; i < word.len(); i++) frame_buf.push_back(word[i]);
	endtask

	function automatic int pick_len();
		int lo;
		lo = sb.payload_off + 1;
		if (lo < 2) lo = 2;
		// with a payload offset this far out only long frames can pass; keep it short
		if (lo > 100) return $urandom_range(2, 20);
		if ($urandom_range(0, 2) == 0) return lo;
		lo = lo + $urandom_range(0, 10);
		return (lo > 127) ? 127 : lo;
	endfunction

	task automatic send_random_frame();
		int    sel;
		int    idx;
		string word;
		sel = $urandom_range(0, 99);
		if (sel < 65) begin
			build_valid_frame(pick_len());
		end else if (sel < 77) begin
			build_valid_frame(pick_len());
			idx = $urandom_range(0, frame_buf.size() - 1);
			frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
		end else if (sel < 87) begin
			word = ($urandom_range(0, 1) == 0) ? "Bootloader" : "ACK";
			build_valid_frame(word.len() + $urandom_range(0, 8));
			idx = $urandom_range(0, frame_buf.size() - word.len());
			for (int i = 0; i < word.len(); i++) frame_buf[idx + i] = word[i];
			// hide the text behind a zero byte now and then
			if (idx > 0 && $urandom_range(0, 2) == 0) frame_buf[$urandom_range(0, idx - 1)] = 8'h00;
		end else if (sel < 99) begin
			build_noise_frame($urandom_range(1, 24));
		end else begin
			build_noise_frame($urandom_range(128, 136));
		end
		send_frame();
	endtask

	task automatic run_random(int budget);
		int stop_at;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) send_random_frame();
	endtask

	initial begin : stimulus
		frame_in.valid = 1'b0;
		frame_in.data_byte = 8'h00;
		frame_in.last_byte = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_START0_VALUE;
		cfg_wdata = 8'h00;
		arst_n = 1'b0;
		bytes_sent = 0;
		frames_sent = 0;
		cycles = 0;
		quiet_tail = 0;
		hold_off_req = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: directed frames first
		build_valid_frame(5);
		send_frame();
		build_valid_frame(6);
		frame_buf[5] = frame_buf[5] ^ 8'h01;
		send_frame();
		frame_buf = '{8'h00};
		send_frame();
		frame_buf.delete();
		append_text("ACK");
		send_frame();
		frame_buf.delete();
		append_text("Bootloader");
		append_text("ACK");
		send_frame();
		frame_buf = '{8'h00};
		append_text("Bootloader");
		send_frame();
		frame_buf = '{8'hFF, 8'h00};
		append_text("ACK");
		send_frame();
		build_noise_frame(128);
		send_frame();
		build_noise_frame(300);
		send_frame();
		run_random(160);
		drain();

		apply_cfg(8'hA5, 8'h5A, 8'h00, 8'h01, 8'h02, 8'h04);
		write_cfg(CFG_SPARE_LO, 8'hFF);
		write_cfg(CFG_SPARE_HI, 8'h00);
		build_valid_frame(5);
		send_frame();
		// stall verdicts for a while and keep bytes flowing
		hold_off_req = 1'b1;
		for (int i = 0; i < 5; i++) begin
			build_valid_frame(5 + i);
			send_frame();
		end
		run_random(160);
		drain();

		// upper bits of the position writes are dropped
		apply_cfg(8'hFF, 8'h00, 8'h83, 8'hFF, 8'h00, 8'h00);
		build_valid_frame(2);
		send_frame();
		build_valid_frame(8);
		send_frame();
		run_random(160);
		drain();

		// every position past the end: only an empty body with FF FF passes
		apply_cfg(8'h00, 8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h00);
		frame_buf = '{8'hFF, 8'hFF};
		send_frame();
		frame_buf = '{8'hFF, 8'hFE};
		send_frame();
		run_random(120);
		drain();

		apply_cfg(8'h3C, 8'hC3, 8'h05, 8'h09, 8'h0C, 8'h7F);
		build_valid_frame(14);
		send_frame();
		run_random(120);
		drain();

		apply_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
			8'($urandom_range(0, 15)), 8'($urandom_range(0, 20)));
		write_cfg(CFG_SPARE_HI, 8'h5A);
		run_random(160);
		quiet_tail = 1;
		run_random(160);
		drain();

		$display("Sent %0d frames (%0d bytes), checked %0d verdicts", frames_sent,
			bytes_sent, sb.verdicts_seen);
		$display("Verdicts ok %0d, boot %0d, ack %0d, header %0d, length %0d, sum %0d",
			sb.status_hits[ST_OK], sb.status_hits[ST_BOOT_TEXT], sb.status_hits[ST_ACK_TEXT],
			sb.status_hits[ST_HEADER_ERR], sb.status_hits[ST_LENGTH_ERR],
			sb.status_hits[ST_CHECKSUM_ERR]);
		if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d verdicts missing", sb.mismatches,
				sb.pending_verdicts.size());
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
